[rtl/sliding_window_rate_meter_assert.svh]
// ----------------------------------------------------------------------------
// sliding window rate meter assertion macros
// Shared property macros, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_RATE_METER_ASSERT_SVH
`define SLIDING_WINDOW_RATE_METER_ASSERT_SVH

// same-cycle implication
`define SWRM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWRM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/swrm_pkg.sv]
// ----------------------------------------------------------------------------
// swrm_pkg
// Widths, constants and shared types of the sliding window rate meter.
// ----------------------------------------------------------------------------
package swrm_pkg;

  // field and state widths
  localparam int BYTE_W   = 20;
  localparam int TIME_W   = 40;
  localparam int RATE_W   = 40;
  localparam int TOTAL_W  = 64;
  localparam int SLOT_W   = 32;
  localparam int DIFF_W   = TOTAL_W - 1;

  // byte difference times 1000 needs 63 + 10 bits
  localparam int WORK_W    = DIFF_W + 10;
  localparam int DIV_STEPS = WORK_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int WINDOW_SLOTS_DEF = 16;

  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  // shared adder operation
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [WORK_W-1:0] a;
    logic [WORK_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [WORK_W-1:0] sum;
    logic              carry;
  } alu_rsp_t;

endpackage

[rtl/swrm_alu.sv]
// ----------------------------------------------------------------------------
// swrm_alu
// Shared wide add/subtract unit; carry out high on subtract means a >= b.
// ----------------------------------------------------------------------------
module swrm_alu (
  input  swrm_pkg::alu_req_t req,
  output swrm_pkg::alu_rsp_t rsp
);

  logic                        is_sub;
  logic [swrm_pkg::WORK_W-1:0] b_eff;
  logic [swrm_pkg::WORK_W:0]   full;

  // two's complement subtract through the same adder
  assign is_sub = (req.op == swrm_pkg::ALU_SUB);
  assign b_eff  = is_sub ? ~req.b : req.b;
  assign full   = {1'b0, req.a} + {1'b0, b_eff} + (swrm_pkg::WORK_W + 1)'(is_sub);

  assign rsp.sum   = full[swrm_pkg::WORK_W-1:0];
  assign rsp.carry = full[swrm_pkg::WORK_W];

endmodule

[rtl/swrm_ring.sv]
// ----------------------------------------------------------------------------
// swrm_ring
// Byte total ring with per-slot valid bits and timestamp ring, registered read.
// ----------------------------------------------------------------------------
module swrm_ring #(
  parameter int DEPTH = swrm_pkg::WINDOW_SLOTS_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr,
  input  logic                         wr_time,
  input  logic [IDX_W-1:0]             wr_idx,
  input  logic [swrm_pkg::TOTAL_W-1:0] wr_bytes,
  input  logic [swrm_pkg::TIME_W-1:0]  wr_ms,
  input  logic                         rd,
  input  logic [IDX_W-1:0]             rd_idx,
  output logic [swrm_pkg::TOTAL_W-1:0] rd_bytes,
  output logic [swrm_pkg::TIME_W-1:0]  rd_ms
);

  logic [swrm_pkg::TOTAL_W-1:0] byte_mem [DEPTH];
  logic [swrm_pkg::TIME_W-1:0]  time_mem [DEPTH];
  logic [DEPTH-1:0]             valid;
  logic [swrm_pkg::TOTAL_W-1:0] byte_q;
  logic                         byte_ok;

  // valid bits: an unwritten byte slot reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (wr) begin
      byte_mem[wr_idx] <= wr_bytes;
    end
    if (wr_time) begin
      time_mem[wr_idx] <= wr_ms;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd) begin
      byte_q  <= byte_mem[rd_idx];
      byte_ok <= valid[rd_idx];
      rd_ms   <= time_mem[rd_idx];
    end
  end

  assign rd_bytes = byte_ok ? byte_q : '0;

endmodule

[rtl/sliding_window_rate_meter.sv]
// ----------------------------------------------------------------------------
// sliding_window_rate_meter
// Byte rate over a sliding window of tick slots, with a shared serial divider.
// ----------------------------------------------------------------------------
// A byte event runs ST_BYTE_ADD and ST_DONE before the next possible input
// transfer; a tick runs ST_TICK_WR through ST_DONE, with ST_DIV the restoring
// divide of (byte difference * 1000) by the millisecond difference, one
// quotient bit per cycle on the single shared 73-bit adder that also does the
// running total, both differences and the multiply by 1000. Each item
// gives one result, the latest rate; if the previous result has not been
// taken, the block holds the new one until the output register frees up.
// No clearing pass after reset: the byte ring uses one valid bit per slot.
module sliding_window_rate_meter #(
  parameter int WINDOW_SLOTS = swrm_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic [swrm_pkg::BYTE_W-1:0] byte_count,
  input  logic [swrm_pkg::TIME_W-1:0] now_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [swrm_pkg::RATE_W-1:0] rate_bytes_per_s
);

  localparam int IDX_W = $clog2(WINDOW_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_SLOTS - 1);

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b00000000001,
    ST_BYTE_ADD = 11'b00000000010,
    ST_TICK_WR  = 11'b00000000100,
    ST_TICK_RD  = 11'b00000001000,
    ST_DIFF     = 11'b00000010000,
    ST_MS       = 11'b00000100000,
    ST_MUL1     = 11'b00001000000,
    ST_MUL2     = 11'b00010000000,
    ST_DIV      = 11'b00100000000,
    ST_RATE     = 11'b01000000000,
    ST_DONE     = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  // architectural state
  logic [swrm_pkg::TOTAL_W-1:0] total;
  logic [swrm_pkg::SLOT_W-1:0]  slot_count;
  logic [IDX_W-1:0]             cur_idx;
  logic [swrm_pkg::RATE_W-1:0]  current_rate;

  // item and work registers
  logic                         action_q;
  logic [swrm_pkg::BYTE_W-1:0]  byte_q;
  logic [swrm_pkg::TIME_W-1:0]  now_q;
  logic [IDX_W-1:0]             chk_idx;
  logic [swrm_pkg::DIFF_W-1:0]  diff;
  logic [swrm_pkg::TIME_W-1:0]  ms;
  logic [swrm_pkg::WORK_W-1:0]  work;
  logic [swrm_pkg::TIME_W-1:0]  rem;
  logic [swrm_pkg::CNT_W-1:0]   cnt;

  // slot advance
  logic [swrm_pkg::SLOT_W-1:0]  slot_count_next;
  logic [IDX_W-1:0]             cur_idx_next;
  logic                         filled;

  // shared unit and ring
  swrm_pkg::alu_req_t           alu_req;
  swrm_pkg::alu_rsp_t           alu_rsp;
  logic                         ring_wr;
  logic                         ring_wr_time;
  logic [swrm_pkg::TOTAL_W-1:0] ring_wr_bytes;
  logic                         ring_rd;
  logic [swrm_pkg::TOTAL_W-1:0] ring_rd_bytes;
  logic [swrm_pkg::TIME_W-1:0]  ring_rd_ms;

  logic                         in_xfer;
  logic                         out_load;
  logic [swrm_pkg::TIME_W:0]    div_shift;
  logic [swrm_pkg::TOTAL_W-1:0] sub64;
  logic [swrm_pkg::TIME_W-1:0]  sub40;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  // next slot indexes; the modulo counter restarts when the slot count wraps
  assign slot_count_next = slot_count + swrm_pkg::SLOT_W'(1);
  assign cur_idx_next    = ((slot_count == '1) || (cur_idx == LAST_IDX)) ?
                           '0 : cur_idx + IDX_W'(1);
  assign filled          = (slot_count_next >= swrm_pkg::SLOT_W'(WINDOW_SLOTS));

  assign div_shift = {rem, work[swrm_pkg::WORK_W-1]};
  assign sub64     = alu_rsp.sum[swrm_pkg::TOTAL_W-1:0];
  assign sub40     = alu_rsp.sum[swrm_pkg::TIME_W-1:0];

  // operand selection for the shared adder
  always_comb begin
    alu_req.op = swrm_pkg::ALU_SUB;
    alu_req.a  = '0;
    alu_req.b  = '0;
    case (state)
      ST_BYTE_ADD: begin
        alu_req.op = swrm_pkg::ALU_ADD;
        alu_req.a  = swrm_pkg::WORK_W'(total);
        alu_req.b  = swrm_pkg::WORK_W'(byte_q);
      end
      ST_DIFF: begin
        alu_req.a = swrm_pkg::WORK_W'(total);
        alu_req.b = swrm_pkg::WORK_W'(ring_rd_bytes);
      end
      ST_MS: begin
        alu_req.a = swrm_pkg::WORK_W'(now_q);
        alu_req.b = swrm_pkg::WORK_W'(ring_rd_ms);
      end
      ST_MUL1: begin
        alu_req.a = {diff, 10'b0};
        alu_req.b = swrm_pkg::WORK_W'({diff, 4'b0});
      end
      ST_MUL2: begin
        alu_req.a = work;
        alu_req.b = swrm_pkg::WORK_W'({diff, 3'b0});
      end
      ST_DIV: begin
        alu_req.a = swrm_pkg::WORK_W'(div_shift);
        alu_req.b = swrm_pkg::WORK_W'(ms);
      end
      default: begin
        alu_req.op = swrm_pkg::ALU_SUB;
      end
    endcase
  end

  swrm_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // ring access
  assign ring_wr       = (state == ST_BYTE_ADD) || (state == ST_TICK_WR);
  assign ring_wr_time  = (state == ST_TICK_WR);
  assign ring_wr_bytes = (state == ST_BYTE_ADD) ? sub64 : total;
  assign ring_rd       = (state == ST_TICK_RD);

  swrm_ring #(
    .DEPTH (WINDOW_SLOTS),
    .IDX_W (IDX_W)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .wr       (ring_wr),
    .wr_time  (ring_wr_time),
    .wr_idx   (cur_idx),
    .wr_bytes (ring_wr_bytes),
    .wr_ms    (now_q),
    .rd       (ring_rd),
    .rd_idx   (chk_idx),
    .rd_bytes (ring_rd_bytes),
    .rd_ms    (ring_rd_ms)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = action ? ST_TICK_WR : ST_BYTE_ADD;
        end
      end
      ST_BYTE_ADD: state_next = ST_DONE;
      ST_TICK_WR:  state_next = ST_TICK_RD;
      ST_TICK_RD:  state_next = ST_DIFF;
      ST_DIFF:     state_next = ST_MS;
      ST_MS:       state_next = ST_MUL1;
      ST_MUL1:     state_next = ST_MUL2;
      ST_MUL2:     state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == swrm_pkg::CNT_W'(swrm_pkg::DIV_STEPS - 1)) begin
          state_next = ST_RATE;
        end
      end
      ST_RATE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      total        <= '0;
      slot_count   <= '0;
      cur_idx      <= '0;
      current_rate <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_BYTE_ADD) begin
        total <= sub64;
      end
      if (state == ST_TICK_WR) begin
        slot_count <= slot_count_next;
        cur_idx    <= cur_idx_next;
      end
      // quotient above the output range saturates
      if (state == ST_RATE) begin
        current_rate <= (|work[swrm_pkg::WORK_W-1:swrm_pkg::RATE_W]) ?
                        swrm_pkg::RATE_MAX : work[swrm_pkg::RATE_W-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item capture and datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      action_q <= action;
      byte_q   <= byte_count;
      now_q    <= now_ms;
    end
    if (out_load) begin
      rate_bytes_per_s <= current_rate;
    end
    case (state)
      // reference slot: slot 0 until the ring has filled, then the oldest
      ST_TICK_WR: begin
        chk_idx <= filled ? cur_idx_next : '0;
      end
      // negative byte difference counts as zero
      ST_DIFF: begin
        diff <= sub64[swrm_pkg::TOTAL_W-1] ? '0 : sub64[swrm_pkg::DIFF_W-1:0];
      end
      // time standing still or going back counts as one ms
      ST_MS: begin
        ms <= (alu_rsp.carry && (sub40 != '0)) ? sub40 : swrm_pkg::TIME_W'(1);
      end
      // times 1000 as times 1024 minus 16 minus 8
      ST_MUL1: begin
        work <= alu_rsp.sum;
      end
      ST_MUL2: begin
        work <= alu_rsp.sum;
        rem  <= '0;
        cnt  <= '0;
      end
      // one restoring divide step, quotient bits shift into work
      ST_DIV: begin
        rem  <= alu_rsp.carry ? sub40 : div_shift[swrm_pkg::TIME_W-1:0];
        work <= {work[swrm_pkg::WORK_W-2:0], alu_rsp.carry};
        cnt  <= cnt + swrm_pkg::CNT_W'(1);
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  // checks
  `include "sliding_window_rate_meter_assert.svh"

  `SWRM_ASSERT_NXT(a_busy_after_xfer, in_xfer, !in_ready, "ready after input transfer")
  `SWRM_ASSERT_IMP(a_cur_in_range, 1'b1, cur_idx <= LAST_IDX, "current slot out of range")
  `SWRM_ASSERT_IMP(a_ms_nonzero, state == ST_MUL1, ms != '0, "zero divisor")
  `SWRM_ASSERT_NXT(a_out_load, out_load, out_valid && (rate_bytes_per_s == $past(current_rate)), "result not loaded")
  `SWRM_ASSERT_IMP(a_byte_path, state == ST_BYTE_ADD, !action_q, "byte path on tick item")

endmodule
